// ===== rtl/mmjs_pkg.sv =====
// Shared types and constants for the min/max jump search block.
// Depends on nothing; used by the controller, datapath and top level.
package mmjs_pkg;

    localparam int unsigned LEN_W   = 31;
    localparam int unsigned JUMPS_W = 11;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_RIVER_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_JUMPS    = 1'd1;

    typedef struct packed {
        logic load;
        logic ins_rd;
        logic ins_shift;
        logic ins_place;
        logic gap_init;
        logic sweep_rd;
        logic gap_step;
        logic srch_init;
        logic walk_init;
        logic walk_step;
        logic decide;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic last;
        logic j_zero;
        logic gt;
        logic k_last;
        logic lo_le_hi;
    } t_status;

endpackage

// ===== rtl/mmjs_ram.sv =====
// Generic single write port RAM with registered read.
// No dependencies.
module mmjs_ram #(
    parameter int unsigned WIDTH = 31,
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/mmjs_ctrl.sv =====
// Controller state machine: insertion, gap sweep, binary search and walk.
// Depends on mmjs_pkg.
module mmjs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  mmjs_pkg::t_status i_status,
    output mmjs_pkg::t_cmd   o_cmd,
    output logic             busy,
    output logic             o_valid
);
    import mmjs_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_INS_RD   = 12'b0000_0000_0010,
        S_INS_CMP  = 12'b0000_0000_0100,
        S_GAP_INIT = 12'b0000_0000_1000,
        S_GAP_RD   = 12'b0000_0001_0000,
        S_GAP_CMP  = 12'b0000_0010_0000,
        S_SRCH     = 12'b0000_0100_0000,
        S_MID      = 12'b0000_1000_0000,
        S_WALK_RD  = 12'b0001_0000_0000,
        S_WALK_CMP = 12'b0010_0000_0000,
        S_DECIDE   = 12'b0100_0000_0000,
        S_DONE     = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        t_state after_ins;
        after_ins = i_status.last ? S_GAP_INIT : S_IDLE;
        n_state   = r_state;
        o_cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_INS_RD;
                end
            end
            S_INS_RD: begin
                if (i_status.full) begin
                    n_state = after_ins;
                end else if (i_status.j_zero) begin
                    o_cmd.ins_place = 1'b1;
                    n_state         = after_ins;
                end else begin
                    o_cmd.ins_rd = 1'b1;
                    n_state      = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                if (i_status.gt) begin
                    o_cmd.ins_shift = 1'b1;
                    n_state         = S_INS_RD;
                end else begin
                    o_cmd.ins_place = 1'b1;
                    n_state         = after_ins;
                end
            end
            S_GAP_INIT: begin
                o_cmd.gap_init = 1'b1;
                n_state        = S_GAP_RD;
            end
            S_GAP_RD: begin
                o_cmd.sweep_rd = 1'b1;
                n_state        = S_GAP_CMP;
            end
            S_GAP_CMP: begin
                o_cmd.gap_step = 1'b1;
                n_state        = i_status.k_last ? S_SRCH : S_GAP_RD;
            end
            S_SRCH: begin
                o_cmd.srch_init = 1'b1;
                n_state         = S_MID;
            end
            S_MID: begin
                if (i_status.lo_le_hi) begin
                    o_cmd.walk_init = 1'b1;
                    n_state         = S_WALK_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_WALK_RD: begin
                o_cmd.sweep_rd = 1'b1;
                n_state        = S_WALK_CMP;
            end
            S_WALK_CMP: begin
                o_cmd.walk_step = 1'b1;
                n_state         = i_status.k_last ? S_DECIDE : S_WALK_RD;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = S_MID;
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);
endmodule

// ===== rtl/mmjs_dp.sv =====
// Datapath: stone store, sort insertion, gap sweep, search bounds, greedy walk.
// Depends on mmjs_pkg and mmjs_ram.
module mmjs_dp #(
    parameter int unsigned MAX_STONES = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mmjs_pkg::t_cmd                 i_cmd,
    input  logic [mmjs_pkg::LEN_W-1:0]     i_stone_position,
    input  logic                           i_last_stone,
    input  logic                           i_cfg_we,
    input  logic [mmjs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mmjs_pkg::LEN_W-1:0]     i_cfg_wdata,
    output mmjs_pkg::t_status              o_status,
    output logic [mmjs_pkg::LEN_W-1:0]     o_min_max_jump
);
    import mmjs_pkg::*;

    localparam int unsigned AW = (MAX_STONES > 1) ? $clog2(MAX_STONES) : 1;
    localparam int unsigned CW = $clog2(MAX_STONES + 1);
    localparam int unsigned KW = $clog2(MAX_STONES + 2);

    logic [LEN_W-1:0]   r_len;
    logic [JUMPS_W-1:0] r_maxj;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_j;
    logic [KW-1:0]      r_k;
    logic [LEN_W-1:0]   r_pos;
    logic               r_last;
    logic [LEN_W-1:0]   r_prev;
    logic [LEN_W-1:0]   r_base;
    logic [LEN_W-1:0]   r_widest;
    logic [LEN_W+1:0]   r_lo;
    logic [LEN_W+1:0]   r_hi;
    logic [LEN_W-1:0]   r_mid;
    logic [KW-1:0]      r_jumps;
    logic [LEN_W-1:0]   r_best;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [LEN_W-1:0] ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [LEN_W-1:0] ram_rdata;

    logic [LEN_W-1:0] point;
    logic [LEN_W-1:0] gap;
    logic [LEN_W-1:0] d_this;
    logic [LEN_W-1:0] d_next;
    logic [LEN_W+1:0] mid_sum;
    logic [CW-1:0]    j_m1;
    logic [KW-1:0]    k_m1;
    logic [KW-1:0]    count_p1;

    mmjs_ram #(.WIDTH(LEN_W), .DEPTH(MAX_STONES), .AW(AW)) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign j_m1      = r_j - CW'(1);
    assign k_m1      = r_k - KW'(1);
    assign count_p1  = KW'(r_count) + KW'(1);
    assign ram_we    = i_cmd.ins_shift | i_cmd.ins_place;
    assign ram_waddr = r_j[AW-1:0];
    assign ram_wdata = i_cmd.ins_shift ? ram_rdata : r_pos;
    assign ram_raddr = i_cmd.ins_rd ? j_m1[AW-1:0] : k_m1[AW-1:0];

    assign point   = (r_k > KW'(r_count)) ? r_len
                   : ((ram_rdata > r_len) ? r_len : ram_rdata);
    assign gap     = point - r_prev;
    assign d_this  = r_prev - r_base;
    assign d_next  = point - r_base;
    assign mid_sum = r_lo + r_hi;

    assign o_status.full     = (r_count == CW'(MAX_STONES));
    assign o_status.last     = r_last;
    assign o_status.j_zero   = (r_j == '0);
    assign o_status.gt       = (ram_rdata > r_pos);
    assign o_status.k_last   = (r_k == count_p1);
    assign o_status.lo_le_hi = ($signed(r_lo) <= $signed(r_hi));
    assign o_min_max_jump    = r_best;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_maxj  <= JUMPS_W'(1);
            r_count <= '0;
            r_best  <= '0;
            r_lo    <= '0;
            r_hi    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_RIVER_LENGTH: r_len  <= i_cfg_wdata;
                    CFG_MAX_JUMPS:    r_maxj <= i_cfg_wdata[JUMPS_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.ins_place) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.srch_init) begin
                r_lo   <= {2'b00, r_widest};
                r_hi   <= {2'b00, r_len};
                r_best <= r_len;
            end
            if (i_cmd.decide) begin
                if (32'(r_jumps) <= 32'(r_maxj)) begin
                    r_best <= r_mid;
                    r_hi   <= {2'b00, r_mid} - (LEN_W+2)'(1);
                end else begin
                    r_lo   <= {2'b00, r_mid} + (LEN_W+2)'(1);
                end
            end
            if (i_cmd.finish) begin
                r_count <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pos  <= i_stone_position;
            r_last <= i_last_stone;
            r_j    <= r_count;
        end
        if (i_cmd.ins_shift) begin
            r_j <= j_m1;
        end
        if (i_cmd.gap_init) begin
            r_prev   <= '0;
            r_widest <= '0;
            r_k      <= KW'(1);
        end
        if (i_cmd.gap_step) begin
            r_prev <= point;
            r_k    <= r_k + KW'(1);
            if (gap > r_widest) begin
                r_widest <= gap;
            end
        end
        if (i_cmd.walk_init) begin
            r_mid   <= mid_sum[LEN_W:1];
            r_base  <= '0;
            r_prev  <= '0;
            r_jumps <= KW'(1);
            r_k     <= KW'(1);
        end
        if (i_cmd.walk_step) begin
            r_prev <= point;
            r_k    <= r_k + KW'(1);
            if (r_k >= KW'(2) && d_this <= r_mid && d_next > r_mid) begin
                r_base  <= r_prev;
                r_jumps <= r_jumps + KW'(1);
            end
        end
    end
endmodule

// ===== rtl/min_max_jump_search.sv =====
// Top level: smallest largest jump over the stones, held sorted by insertion, up to MAX_STONES.
// A stone is taken on start while idle; busy then stays high while it is moved past each larger
// stored stone and placed (dropped when the store is full). Next stone is taken once busy drops.
// After the last stone: a gap sweep and search set-up, then per search step a greedy walk over
// the stones and a decision, at most 32 steps; then the search closes with o_valid for one cycle.
// Synchronous active-low reset inits control state and configuration, not the store; no stall.
module min_max_jump_search #(
    parameter int unsigned MAX_STONES = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [mmjs_pkg::LEN_W-1:0]     i_stone_position,
    input  logic                           i_last_stone,
    input  logic                           i_cfg_we,
    input  logic [mmjs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mmjs_pkg::LEN_W-1:0]     i_cfg_wdata,
    output logic                           o_valid,
    output logic [mmjs_pkg::LEN_W-1:0]     o_min_max_jump
);
    import mmjs_pkg::*;

    t_cmd    cmd;
    t_status status;

    mmjs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_status(status),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_valid (o_valid)
    );

    mmjs_dp #(.MAX_STONES(MAX_STONES)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_stone_position(i_stone_position),
        .i_last_stone    (i_last_stone),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_status        (status),
        .o_min_max_jump  (o_min_max_jump)
    );
endmodule
